[hdl/ssfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfe_pkg
// Shared types, operation codes and segment tables of the frame encoder.
// ----------------------------------------------------------------------------
package ssfe_pkg;

   localparam int QueueDepth = 2;

   localparam logic [2:0] OP_NUM_ALL   = 3'd0;
   localparam logic [2:0] OP_NUM_UPPER = 3'd1;
   localparam logic [2:0] OP_NUM_LOWER = 3'd2;
   localparam logic [2:0] OP_TXT_UPPER = 3'd3;
   localparam logic [2:0] OP_TXT_LOWER = 3'd4;

   // reciprocal of ten, scaled by 2^35, exact for any 32-bit value
   localparam logic [31:0] RECIP_TEN  = 32'hCCCCCCCD;
   localparam int          RECIP_SHIFT = 35;

   typedef struct packed {
      logic             text;
      logic             all_digits;
      logic             upper;
      logic [31:0]      num;
      logic [3:0][7:0]  chars;   // index 3 is the rightmost character
   } entry_type;

   function automatic logic [7:0] digit_seg(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0:    s = 8'hFC;
         4'd1:    s = 8'h60;
         4'd2:    s = 8'hDA;
         4'd3:    s = 8'hF2;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'hB6;
         4'd6:    s = 8'hBE;
         4'd7:    s = 8'hE0;
         4'd8:    s = 8'hFE;
         4'd9:    s = 8'hF6;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] letter_seg(input logic [7:0] ch);
      logic [7:0] s;
      case (ch)
         8'h30:   s = 8'hFC;   // '0'
         8'h31:   s = 8'h60;
         8'h32:   s = 8'hDA;
         8'h33:   s = 8'hF2;
         8'h34:   s = 8'h66;
         8'h35:   s = 8'hB6;
         8'h36:   s = 8'hBE;
         8'h37:   s = 8'hE0;
         8'h38:   s = 8'hFE;
         8'h39:   s = 8'hF6;   // '9'
         8'h41:   s = 8'hEE;   // 'A'
         8'h42:   s = 8'h3E;
         8'h43:   s = 8'h9C;
         8'h44:   s = 8'h7A;
         8'h45:   s = 8'h9E;
         8'h46:   s = 8'h8E;   // 'F'
         8'h4C:   s = 8'h1C;   // 'L'
         8'h4E:   s = 8'hEC;   // 'N'
         8'h4F:   s = 8'hFC;   // 'O'
         8'h50:   s = 8'hCE;   // 'P'
         8'h52:   s = 8'h0A;   // 'R'
         8'h53:   s = 8'hB6;   // 'S'
         8'h54:   s = 8'h1E;   // 'T'
         8'h55:   s = 8'h7C;   // 'U'
         default: s = 8'h00;
      endcase
      return s;
   endfunction

endpackage

[hdl/ssfe_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfe_front
// Decodes a display command into a queue entry and drops unused codes.
// ----------------------------------------------------------------------------
module ssfe_front (
   input  logic                 req_valid,
   input  logic [2:0]           req_operation,
   input  logic [31:0]          req_value,
   input  logic [7:0]           req_text_char0,
   input  logic [7:0]           req_text_char1,
   input  logic [7:0]           req_text_char2,
   input  logic [7:0]           req_text_char3,
   input  logic                 queue_full,
   output logic                 req_stall,
   output logic                 push,
   output ssfe_pkg::entry_type  push_entry
);

   logic op_ok;

   always_comb begin
      push_entry.chars = {req_text_char3, req_text_char2, req_text_char1, req_text_char0};
      push_entry.num   = req_value;
      op_ok            = 1'b1;
      case (req_operation)
         ssfe_pkg::OP_NUM_ALL: begin
            push_entry.text       = 1'b0;
            push_entry.all_digits = 1'b1;
            push_entry.upper      = 1'b0;
         end
         ssfe_pkg::OP_NUM_UPPER: begin
            push_entry.text       = 1'b0;
            push_entry.all_digits = 1'b0;
            push_entry.upper      = 1'b1;
            push_entry.num        = {16'd0, req_value[15:0]};
         end
         ssfe_pkg::OP_NUM_LOWER: begin
            push_entry.text       = 1'b0;
            push_entry.all_digits = 1'b0;
            push_entry.upper      = 1'b0;
            push_entry.num        = {16'd0, req_value[15:0]};
         end
         ssfe_pkg::OP_TXT_UPPER: begin
            push_entry.text       = 1'b1;
            push_entry.all_digits = 1'b0;
            push_entry.upper      = 1'b1;
         end
         ssfe_pkg::OP_TXT_LOWER: begin
            push_entry.text       = 1'b1;
            push_entry.all_digits = 1'b0;
            push_entry.upper      = 1'b0;
         end
         default: begin
            // unused codes give no frame
            push_entry.text       = 1'b0;
            push_entry.all_digits = 1'b0;
            push_entry.upper      = 1'b0;
            op_ok                 = 1'b0;
         end
      endcase
   end

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full & op_ok;

endmodule

[hdl/ssfe_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfe_queue
// Small command queue between the decode front and the frame back end.
// ----------------------------------------------------------------------------
module ssfe_queue #(
   parameter int Depth = ssfe_pkg::QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ssfe_pkg::entry_type  push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output ssfe_pkg::entry_type  head_entry
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

   ssfe_pkg::entry_type store_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == DepthCnt);
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[hdl/ssfe_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfe_back
// Walks one command digit by digit and drives the registered frame output.
// ----------------------------------------------------------------------------
module ssfe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  ssfe_pkg::entry_type  head_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_digit_select,
   output logic [7:0]           rsp_segments,
   output logic                 rsp_last
);

   logic                busy_ff, busy_in;
   ssfe_pkg::entry_type work_ff, work_in;
   logic [2:0]          idx_ff, idx_in;
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          sel_ff, sel_in;
   logic [7:0]          seg_ff, seg_in;
   logic                last_ff, last_in;

   ssfe_pkg::entry_type src;
   logic [2:0]          src_idx;
   logic                fire;
   logic [63:0]         prod;
   logic [28:0]         quot;
   logic [31:0]         quot_x10;
   logic [3:0]          rem;
   logic [2:0]          digit;
   logic                is_last;

   // a fresh command is served straight from the queue head
   assign src     = busy_ff ? work_ff : head_entry;
   assign src_idx = busy_ff ? idx_ff : 3'd0;
   assign fire    = (busy_ff | head_valid) & (~out_valid_ff | ~rsp_stall);
   assign pop     = fire & ~busy_ff;

   assign prod     = {32'd0, src.num} * {32'd0, ssfe_pkg::RECIP_TEN};
   assign quot     = prod[63:ssfe_pkg::RECIP_SHIFT];
   assign quot_x10 = {quot[28:0], 3'b000} + {2'b00, quot[28:0], 1'b0};
   assign rem      = 4'(src.num - quot_x10);

   assign digit   = src.all_digits ? src_idx : {src.upper, src_idx[1:0]};
   assign is_last = src.all_digits ? (src_idx == 3'd7) : (src_idx[1:0] == 2'd3);

   always_comb begin
      busy_in      = busy_ff;
      work_in      = work_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff & rsp_stall;
      sel_in       = sel_ff;
      seg_in       = seg_ff;
      last_in      = last_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         sel_in       = ~(8'd1 << digit);
         seg_in       = src.text ? ssfe_pkg::letter_seg(src.chars[3])
                                 : ssfe_pkg::digit_seg(rem);
         last_in      = is_last;
         busy_in      = ~is_last;
         work_in      = src;
         work_in.num  = {3'd0, quot};
         work_in.chars = {src.chars[2:0], 8'd0};
         idx_in       = src_idx + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      idx_ff  <= idx_in;
      sel_ff  <= sel_in;
      seg_ff  <= seg_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_digit_select = sel_ff;
   assign rsp_segments     = seg_ff;
   assign rsp_last         = last_ff;

endmodule

[hdl/seven_segment_frame_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_frame_encoder
// Turns display commands into per-digit frames for an eight-digit display.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   operation, value, text_char0..3
//   rsp      out        rsp_valid/rsp_stall   digit_select, segments, last
//
// One frame leaves per cycle while rsp does not stall, eight for an all-digit
// number and four for the other modes, from the one divide-by-ten multiply.
// Unused operation codes are taken while the queue has room and give no frame.
// Reset is synchronous and clears the queue and the frame valid.
// The front takes new commands while the queue has room, even when rsp stalls.
// ----------------------------------------------------------------------------
module seven_segment_frame_encoder #(
   parameter int QueueDepth = ssfe_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_value,
   input  logic [7:0]  req_text_char0,
   input  logic [7:0]  req_text_char1,
   input  logic [7:0]  req_text_char2,
   input  logic [7:0]  req_text_char3,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_digit_select,
   output logic [7:0]  rsp_segments,
   output logic        rsp_last
);

   logic                push;
   logic                pop;
   logic                queue_full;
   logic                head_valid;
   ssfe_pkg::entry_type push_entry;
   ssfe_pkg::entry_type head_entry;

   ssfe_front u_front (
      .req_valid      (req_valid),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .req_text_char0 (req_text_char0),
      .req_text_char1 (req_text_char1),
      .req_text_char2 (req_text_char2),
      .req_text_char3 (req_text_char3),
      .queue_full     (queue_full),
      .req_stall      (req_stall),
      .push           (push),
      .push_entry     (push_entry)
   );

   ssfe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   ssfe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit_select (rsp_digit_select),
      .rsp_segments     (rsp_segments),
      .rsp_last         (rsp_last)
   );

endmodule

[sim/seven_segment_frame_encoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_frame_encoder_tb
// Self-checking bench for the display frame encoder. A directed table covers
// every mode, the blank and unknown characters, over-wide numbers and the
// spare operation codes. Random commands follow under three idling patterns,
// including one long stall on the frame side. Every frame is checked against
// a behavioural predictor in arrival order.
// ----------------------------------------------------------------------------
module seven_segment_frame_encoder_tb;

   localparam logic [2:0] OP_SPARE_LOW  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID  = 3'd6;
   localparam logic [2:0] OP_SPARE_HIGH = 3'd7;

   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int REPORT_LIMIT   = 10;

   // characters the glyph table knows, picked from at random
   localparam logic [8*24-1:0] KNOWN_CHARS = "0123456789ABCDEFLNOPRSTU";

   localparam logic [7:0] DIGIT_GLYPHS [10] = '{
      8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
   };

   typedef struct packed {
      logic [7:0] digit_select;
      logic [7:0] segments;
      logic       last;
   } frame_type;

   // text holds char0 in the top byte, char3 in the bottom byte
   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] value;
      logic [31:0] text;
      logic        seg_known;
      logic [7:0]  seg;
   } cmd_row_type;

   localparam int DIRECTED_COUNT = 24;
   localparam cmd_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{ssfe_pkg::OP_NUM_ALL,   32'd0,          32'h0,       1'b1, 8'hFC},
      '{ssfe_pkg::OP_NUM_ALL,   32'd88888888,   32'h0,       1'b1, 8'hFE},
      '{ssfe_pkg::OP_NUM_ALL,   32'd99999999,   32'h0,       1'b1, 8'hF6},
      '{ssfe_pkg::OP_NUM_ALL,   32'd100000000,  32'h0,       1'b1, 8'hFC},
      '{ssfe_pkg::OP_NUM_ALL,   32'hFFFF_FFFF,  32'h0,       1'b0, 8'h00},
      '{ssfe_pkg::OP_NUM_ALL,   32'd12345678,   32'hFFFF_FFFF, 1'b0, 8'h00},
      '{ssfe_pkg::OP_NUM_UPPER, 32'd0,          32'h0,       1'b1, 8'hFC},
      '{ssfe_pkg::OP_NUM_UPPER, 32'd8888,       32'h0,       1'b1, 8'hFE},
      '{ssfe_pkg::OP_NUM_UPPER, 32'hFFFF_FFFF,  32'h0,       1'b0, 8'h00},
      '{ssfe_pkg::OP_NUM_LOWER, 32'd9999,       32'h0,       1'b1, 8'hF6},
      '{ssfe_pkg::OP_NUM_LOWER, 32'hABCD_0000,  32'h0,       1'b1, 8'hFC},
      '{ssfe_pkg::OP_NUM_LOWER, 32'h0001_2345,  32'h0,       1'b0, 8'h00},
      '{ssfe_pkg::OP_TXT_UPPER, 32'hFFFF_FFFF,  "0123",      1'b0, 8'h00},
      '{ssfe_pkg::OP_TXT_UPPER, 32'd0,          "4567",      1'b0, 8'h00},
      '{ssfe_pkg::OP_TXT_LOWER, 32'd0,          "89AB",      1'b0, 8'h00},
      '{ssfe_pkg::OP_TXT_LOWER, 32'd0,          "CDEF",      1'b0, 8'h00},
      '{ssfe_pkg::OP_TXT_UPPER, 32'd0,          "LNOP",      1'b0, 8'h00},
      '{ssfe_pkg::OP_TXT_LOWER, 32'd0,          "RSTU",      1'b0, 8'h00},
      '{ssfe_pkg::OP_TXT_UPPER, 32'd0,          "    ",      1'b1, 8'h00},
      '{ssfe_pkg::OP_TXT_LOWER, 32'd0,          32'hFFFF_FFFF, 1'b1, 8'h00},
      '{ssfe_pkg::OP_TXT_UPPER, 32'd0,          32'h8000_6147, 1'b1, 8'h00},
      '{OP_SPARE_LOW,  32'd1234,      "ABCD",      1'b0, 8'h00},
      '{OP_SPARE_MID,  32'hFFFF_FFFF, "0000",      1'b0, 8'h00},
      '{OP_SPARE_HIGH, 32'd0,         32'hFFFF_FFFF, 1'b0, 8'h00}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_operation;
   logic [31:0] req_value;
   logic [7:0]  req_text_char0;
   logic [7:0]  req_text_char1;
   logic [7:0]  req_text_char2;
   logic [7:0]  req_text_char3;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_digit_select;
   logic [7:0]  rsp_segments;
   logic        rsp_last;

   // typed expectation riding alongside the command word being offered
   logic        offer_seg_known;
   logic [7:0]  offer_seg;

   frame_type pending_frames [$];
   int        mismatch_count;
   int        watchdog_cycles;
   int        send_idle_pct;
   int        recv_idle_pct;
   bit        hold_request;

   seven_segment_frame_encoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .req_text_char0   (req_text_char0),
      .req_text_char1   (req_text_char1),
      .req_text_char2   (req_text_char2),
      .req_text_char3   (req_text_char3),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit_select (rsp_digit_select),
      .rsp_segments     (rsp_segments),
      .rsp_last         (rsp_last)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic [7:0] char_glyph(input logic [7:0] ch);
      logic [7:0] glyph;
      glyph = 8'h00;
      if (ch >= "0" && ch <= "9") begin
         glyph = DIGIT_GLYPHS[ch - "0"];
      end else begin
         case (ch)
            "A": glyph = 8'hEE;
            "B": glyph = 8'h3E;
            "C": glyph = 8'h9C;
            "D": glyph = 8'h7A;
            "E": glyph = 8'h9E;
            "F": glyph = 8'h8E;
            "L": glyph = 8'h1C;
            "N": glyph = 8'hEC;
            "O": glyph = 8'hFC;
            "P": glyph = 8'hCE;
            "R": glyph = 8'h0A;
            "S": glyph = 8'hB6;
            "T": glyph = 8'h1E;
            "U": glyph = 8'h7C;
            default: glyph = 8'h00;
         endcase
      end
      return glyph;
   endfunction

   // queues the frames one command should produce, lowest digit of the group first
   function automatic void encode_display_frames(input logic [2:0] op, input logic [31:0] value,
                                                 input logic [31:0] text, input logic seg_known,
                                                 input logic [7:0] seg);
      int          count;
      int          base;
      int          i;
      logic [31:0] num;
      frame_type   f;
      num   = value;
      count = 4;
      base  = 0;
      case (op)
         ssfe_pkg::OP_NUM_ALL: begin
            count = 8;
         end
         ssfe_pkg::OP_NUM_UPPER: begin
            base = 4;
            num  = {16'd0, value[15:0]};
         end
         ssfe_pkg::OP_NUM_LOWER: begin
            num = {16'd0, value[15:0]};
         end
         ssfe_pkg::OP_TXT_UPPER: begin
            base = 4;
         end
         ssfe_pkg::OP_TXT_LOWER: begin
            base = 0;
         end
         default: begin
            count = 0;
         end
      endcase
      for (i = 0; i < count; i++) begin
         f.digit_select = ~(8'd1 << (base + i));
         if (op == ssfe_pkg::OP_TXT_UPPER || op == ssfe_pkg::OP_TXT_LOWER) begin
            f.segments = char_glyph(text[8*i +: 8]);
         end else begin
            f.segments = DIGIT_GLYPHS[num % 10];
            num = num / 10;
         end
         if (seg_known) begin
            f.segments = seg;
         end
         f.last = (i == count - 1);
         pending_frames.push_back(f);
      end
   endfunction

   // entered and left at a falling edge; valid stays up between back-to-back words
   task automatic send_command(input logic [2:0] op, input logic [31:0] value,
                               input logic [31:0] text, input logic seg_known,
                               input logic [7:0] seg);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_value       <= value;
      req_text_char0  <= text[31:24];
      req_text_char1  <= text[23:16];
      req_text_char2  <= text[15:8];
      req_text_char3  <= text[7:0];
      offer_seg_known <= seg_known;
      offer_seg       <= seg;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic send_random_commands(input int n);
      int          sent;
      int          k;
      logic [2:0]  op;
      logic [31:0] value;
      logic [31:0] text;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(0, 9) == 0) begin
            op = 3'($urandom_range(OP_SPARE_LOW, OP_SPARE_HIGH));
         end else begin
            op = 3'($urandom_range(ssfe_pkg::OP_NUM_ALL, ssfe_pkg::OP_TXT_LOWER));
            sent++;
         end
         case ($urandom_range(0, 3))
            0:       value = $urandom;
            1:       value = $urandom_range(0, 9999);
            2:       value = $urandom_range(0, 99999999);
            default: value = $urandom_range(99999990, 100000010);
         endcase
         for (k = 0; k < 4; k++) begin
            if ($urandom_range(0, 9) < 7) begin
               text[8*k +: 8] = KNOWN_CHARS[8*$urandom_range(0, 23) +: 8];
            end else begin
               text[8*k +: 8] = 8'($urandom_range(0, 255));
            end
         end
         send_command(op, value, text, 1'b0, 8'h00);
      end
   endtask

   // frame side: random stalls, plus one long hold-off on request
   initial begin : frame_receiver
      bit held;
      held      = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            repeat (HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : frame_checker
      logic      took_cmd;
      logic      took_frame;
      frame_type want;
      took_cmd   = 1'b0;
      took_frame = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            took_cmd = 1'b1;
            encode_display_frames(req_operation, req_value,
                                  {req_text_char0, req_text_char1,
                                   req_text_char2, req_text_char3},
                                  offer_seg_known, offer_seg);
         end
         if (rsp_valid && !rsp_stall) begin
            took_frame = 1'b1;
            if (pending_frames.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("unexpected frame: select %h segments %h last %b",
                           rsp_digit_select, rsp_segments, rsp_last);
               end
            end else begin
               want = pending_frames.pop_front();
               if (rsp_digit_select !== want.digit_select || rsp_segments !== want.segments ||
                   rsp_last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("frame mismatch: expected select %h segments %h last %b, got %h %h %b",
                              want.digit_select, want.segments, want.last,
                              rsp_digit_select, rsp_segments, rsp_last);
                  end
               end
            end
         end
         if (took_cmd || took_frame) begin
            watchdog_cycles = 0;
         end else begin
            watchdog_cycles++;
         end
         if (watchdog_cycles >= WATCHDOG_LIMIT) begin
            $display("seven_segment_frame_encoder regression: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int row;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = ssfe_pkg::OP_NUM_ALL;
      req_value       = 32'd0;
      req_text_char0  = 8'd0;
      req_text_char1  = 8'd0;
      req_text_char2  = 8'd0;
      req_text_char3  = 8'd0;
      offer_seg_known = 1'b0;
      offer_seg       = 8'd0;
      mismatch_count  = 0;
      watchdog_cycles = 0;
      hold_request    = 1'b0;
      send_idle_pct   = 14;
      recv_idle_pct   = 63;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_COUNT; row++) begin
         send_command(DIRECTED_ROWS[row].op, DIRECTED_ROWS[row].value, DIRECTED_ROWS[row].text,
                      DIRECTED_ROWS[row].seg_known, DIRECTED_ROWS[row].seg);
      end

      // long hold-off on the frame side while words keep coming, so the queue backs up
      hold_request = 1'b1;
      send_random_commands(26);

      send_idle_pct = 63;
      recv_idle_pct = 14;
      send_random_commands(25);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_commands(25);

      req_valid <= 1'b0;
      while (pending_frames.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_frames.size() == 0) begin
         $display("seven_segment_frame_encoder regression: pass");
      end else begin
         $display("seven_segment_frame_encoder regression: fail");
      end
      $finish;
   end

endmodule
